// ===== hdl/hwvg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the harmonic wind vector generator.
package hwvg_pkg;

    localparam int DEF_MAX_HARMONICS = 16;
    localparam int CFG_IDX_W         = 3;

    // Item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd5;

    localparam logic [4:0]  COUNT_RESET     = 5'd16;
    localparam logic [33:0] TURN_PER_RAD    = 34'd683565276;
    // 2^48/360 split at bit 32
    localparam logic [33:0] TURN_PER_DEG_HI = 34'd182;
    localparam logic [33:0] TURN_PER_DEG_LO = 34'd190887435;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0] POLY_K9         = 32'd172272;
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam logic [16:0] RAMP_STEP       = 17'd1092;
    localparam logic [31:0] FRAME_LIMIT     = 32'hFFFF_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_cosine;
        logic signed [31:0] coef_sine;
        logic [23:0]        frame_delta;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] wind_x;
        logic signed [31:0] wind_y;
        logic signed [31:0] wind_z;
    } t_out_item;

    // Horner coefficients of the quarter-wave sine, highest order first
    function automatic logic [31:0] horner_coef(input logic [1:0] idx);
        logic [31:0] k;
        case (idx)
            2'd0:    k = 32'd5026995;
            2'd1:    k = 32'd85569306;
            2'd2:    k = 32'd693598668;
            default: k = 32'd1686629713;
        endcase
        return k;
    endfunction

    // Round half up from Q32 to Q16
    function automatic logic signed [67:0] round16(input logic signed [67:0] v);
        return (v + 68'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/harmonic_wind_vector_generator.sv =====
// Top level of the harmonic wind vector generator: sequencer around one shared multiplier.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries three kinds of
// transaction: a tick builds one wind vector, a load writes one coefficient pair, and a
// clear resets ramp strength and frame position. Load, clear and unknown opcodes finish
// in the accepting cycle and produce nothing.
// A tick runs through a sequencer that drives a single 34x34 signed multiplier. Every
// micro-step has an issue half and a write-back half; each sine or cosine takes six steps.
// o_in_stall stays high for the whole of a tick, while the sequencer is busy. The result
// appears on o_out_valid / o_out_data at the same edge at which o_in_stall drops.
// The output register holds one finished vector. A tick may be accepted while the
// previous vector still waits; if the receiver holds i_out_stall high, the sequencer
// waits at its last step until the register frees, and nothing is dropped.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once and are
// meant only while no tick is in progress. Writes to unknown indexes are ignored.
// Synchronous reset clears configuration (count back to 16), coefficients, frame,
// strength and the output valid flag.
module harmonic_wind_vector_generator #(
    parameter int MAX_HARMONICS = hwvg_pkg::DEF_MAX_HARMONICS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hwvg_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hwvg_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [hwvg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import hwvg_pkg::*;

    localparam int IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CNT_W = $clog2(MAX_HARMONICS + 1);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_PH_RAD   = 5'd1;
    localparam logic [4:0] ST_PH_LO    = 5'd2;
    localparam logic [4:0] ST_PH_HI    = 5'd3;
    localparam logic [4:0] ST_HM_START = 5'd4;
    localparam logic [4:0] ST_HM_C     = 5'd5;
    localparam logic [4:0] ST_HM_S     = 5'd6;
    localparam logic [4:0] ST_SN_A2    = 5'd7;
    localparam logic [4:0] ST_SN_H     = 5'd8;
    localparam logic [4:0] ST_SN_PA    = 5'd9;
    localparam logic [4:0] ST_SC_RND   = 5'd10;
    localparam logic [4:0] ST_SC_BIAS  = 5'd11;
    localparam logic [4:0] ST_SC_SCALE = 5'd12;
    localparam logic [4:0] ST_ANG_LO   = 5'd13;
    localparam logic [4:0] ST_ANG_HI   = 5'd14;
    localparam logic [4:0] ST_ANG_C    = 5'd15;
    localparam logic [4:0] ST_ANG_S    = 5'd16;
    localparam logic [4:0] ST_VX_XY    = 5'd17;
    localparam logic [4:0] ST_VX_X1    = 5'd18;
    localparam logic [4:0] ST_VX_X2    = 5'd19;
    localparam logic [4:0] ST_VX_Y1    = 5'd20;
    localparam logic [4:0] ST_VX_Y2    = 5'd21;
    localparam logic [4:0] ST_VX_Z1    = 5'd22;
    localparam logic [4:0] ST_VX_Z2    = 5'd23;
    localparam logic [4:0] ST_DONE     = 5'd24;

    // configuration
    logic signed [31:0] r_scale, r_cycle, r_yaw, r_roll, r_bias;
    logic [4:0]         r_count;

    // state
    logic signed [31:0] r_coef_c [MAX_HARMONICS];
    logic signed [31:0] r_coef_s [MAX_HARMONICS];
    logic [31:0]        r_frame;
    logic [16:0]        r_ramp;

    // sequencer and datapath
    logic [4:0]         r_state, r_ret;
    logic               r_half, r_axis;
    logic [CNT_W-1:0]   r_i;
    logic [1:0]         r_hk;
    logic signed [67:0] r_prod;
    logic [63:0]        r_rad;
    logic [31:0]        r_base, r_turn, r_t32, r_p;
    logic [30:0]        r_a2;
    logic signed [17:0] r_sin, r_cy, r_sy, r_cz, r_sz;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_val, r_x, r_y;
    logic signed [33:0] r_xy, r_t1;
    logic [23:0]        r_delta;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod, w_rnd;
    logic [16:0]        w_f, w_x;
    logic [30:0]        w_a;
    logic [34:0]        w_q;
    logic [20:0]        w_r;
    logic [16:0]        w_rcap;
    logic signed [31:0] w_deg;
    logic [5:0]         w_n;
    logic [IDX_W-1:0]   w_idx;
    logic               w_out_free;
    logic [32:0]        n_frame_sum;
    logic [31:0]        n_frame;
    logic [17:0]        n_ramp_sum;
    logic [16:0]        n_ramp;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_n   = ({1'b0, r_count} > 6'(MAX_HARMONICS)) ? 6'(MAX_HARMONICS) : {1'b0, r_count};
    assign w_idx = r_i[IDX_W-1:0];
    assign w_deg = r_axis ? r_roll : r_yaw;

    // quarter-wave argument: mirror in odd quadrants
    assign w_f = {1'b0, r_turn[29:14]};
    assign w_x = r_turn[30] ? (ONE_Q16 - w_f) : w_f;
    assign w_a = {w_x, 14'd0};

    assign w_q    = {1'b0, r_prod[63:30]} + 35'd8192;
    assign w_r    = w_q[34:14];
    assign w_rcap = (w_r > {4'd0, ONE_Q16}) ? ONE_Q16 : w_r[16:0];

    assign w_rnd = round16(r_prod);

    assign n_frame_sum = {1'b0, r_frame} + {9'd0, r_delta};
    assign n_frame     = (n_frame_sum > {1'b0, FRAME_LIMIT}) ? 32'd0 : n_frame_sum[31:0];
    assign n_ramp_sum  = {1'b0, r_ramp} + {1'b0, RAMP_STEP};
    assign n_ramp      = (n_ramp_sum >= {1'b0, ONE_Q16}) ? ONE_Q16 : n_ramp_sum[16:0];

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_PH_RAD: begin
                w_ma = $signed({{2{r_cycle[31]}}, r_cycle});
                w_mb = $signed({2'b0, r_frame});
            end
            ST_PH_LO: begin
                w_ma = $signed({2'b0, r_rad[31:0]});
                w_mb = $signed(TURN_PER_RAD);
            end
            ST_PH_HI: begin
                w_ma = $signed({2'b0, r_rad[63:32]});
                w_mb = $signed(TURN_PER_RAD);
            end
            ST_HM_C: begin
                w_ma = $signed({{16{r_sin[17]}}, r_sin});
                w_mb = $signed({{2{r_coef_c[w_idx][31]}}, r_coef_c[w_idx]});
            end
            ST_HM_S: begin
                w_ma = $signed({{16{r_sin[17]}}, r_sin});
                w_mb = $signed({{2{r_coef_s[w_idx][31]}}, r_coef_s[w_idx]});
            end
            ST_SN_A2: begin
                w_ma = $signed({3'b0, w_a});
                w_mb = $signed({3'b0, w_a});
            end
            ST_SN_H: begin
                w_ma = $signed({2'b0, r_p});
                w_mb = $signed({3'b0, r_a2});
            end
            ST_SN_PA: begin
                w_ma = $signed({2'b0, r_p});
                w_mb = $signed({3'b0, w_a});
            end
            ST_SC_SCALE: begin
                w_ma = $signed({{2{r_val[31]}}, r_val});
                w_mb = $signed({{2{r_scale[31]}}, r_scale});
            end
            ST_ANG_LO: begin
                w_ma = $signed({{2{w_deg[31]}}, w_deg});
                w_mb = $signed(TURN_PER_DEG_LO);
            end
            ST_ANG_HI: begin
                w_ma = $signed({{2{w_deg[31]}}, w_deg});
                w_mb = $signed(TURN_PER_DEG_HI);
            end
            ST_VX_XY: begin
                w_ma = $signed({{2{r_val[31]}}, r_val});
                w_mb = $signed({{16{r_cy[17]}}, r_cy});
            end
            ST_VX_X1: begin
                w_ma = r_xy;
                w_mb = $signed({{16{r_cz[17]}}, r_cz});
            end
            ST_VX_Y1: begin
                w_ma = r_xy;
                w_mb = $signed({{16{r_sz[17]}}, r_sz});
            end
            ST_VX_Z1: begin
                w_ma = $signed({{2{r_val[31]}}, r_val});
                w_mb = $signed({{16{r_sy[17]}}, r_sy});
            end
            ST_VX_X2, ST_VX_Y2, ST_VX_Z2, ST_DONE: begin
                w_ma = r_t1;
                w_mb = $signed({17'd0, r_ramp});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_scale     <= '0;
            r_cycle     <= '0;
            r_yaw       <= '0;
            r_roll      <= '0;
            r_bias      <= '0;
            r_count     <= COUNT_RESET;
            r_frame     <= '0;
            r_ramp      <= '0;
            r_state     <= ST_IDLE;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_HARMONICS; j++) begin
                r_coef_c[j] <= '0;
                r_coef_s[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALE: r_scale <= i_cfg_data;
                    CFG_CYCLE: r_cycle <= i_cfg_data;
                    CFG_YAW:   r_yaw   <= i_cfg_data;
                    CFG_ROLL:  r_roll  <= i_cfg_data;
                    CFG_BIAS:  r_bias  <= i_cfg_data;
                    CFG_COUNT: r_count <= i_cfg_data[4:0];
                    default:   ;
                endcase
            end

            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_IDLE) begin
                if (i_in_valid) begin
                    case (i_in_data.opcode)
                        OP_TICK: begin
                            r_state <= ST_PH_RAD;
                            r_half  <= 1'b0;
                            r_delta <= i_in_data.frame_delta;
                        end
                        OP_LOAD: begin
                            for (int j = 0; j < MAX_HARMONICS; j++) begin
                                if (32'(j) == 32'(i_in_data.coef_index)) begin
                                    r_coef_c[j] <= i_in_data.coef_cosine;
                                    r_coef_s[j] <= i_in_data.coef_sine;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            r_ramp  <= '0;
                            r_frame <= '0;
                        end
                        default: ;
                    endcase
                end
            end else if (r_state == ST_DONE) begin
                // hold until the output register frees
                if (w_out_free) begin
                    r_out_valid       <= 1'b1;
                    r_out_data.wind_x <= r_x;
                    r_out_data.wind_y <= r_y;
                    r_out_data.wind_z <= sat32(w_rnd);
                    r_ramp            <= n_ramp;
                    r_frame           <= n_frame;
                    r_state           <= ST_IDLE;
                end
            end else if (!r_half) begin
                r_half <= 1'b1;
            end else begin
                r_half <= 1'b0;
                case (r_state)
                    ST_PH_RAD: begin
                        r_rad   <= r_prod[63:0];
                        r_state <= ST_PH_LO;
                    end
                    ST_PH_LO: begin
                        r_base  <= r_prod[63:32];
                        r_state <= ST_PH_HI;
                    end
                    ST_PH_HI: begin
                        r_base  <= r_base + r_prod[31:0];
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_state <= ST_HM_START;
                    end
                    ST_HM_START: begin
                        if (6'(r_i) >= w_n) begin
                            r_state <= ST_SC_RND;
                        end else begin
                            r_turn  <= (r_base << r_i) + QUARTER_TURN;
                            r_ret   <= ST_HM_C;
                            r_state <= ST_SN_A2;
                        end
                    end
                    ST_HM_C: begin
                        r_acc   <= r_acc + r_prod[63:0];
                        r_turn  <= r_base << r_i;
                        r_ret   <= ST_HM_S;
                        r_state <= ST_SN_A2;
                    end
                    ST_HM_S: begin
                        r_acc   <= r_acc + r_prod[63:0];
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= ST_HM_START;
                    end
                    ST_SN_A2: begin
                        r_a2    <= r_prod[60:30];
                        r_p     <= POLY_K9;
                        r_hk    <= '0;
                        r_state <= ST_SN_H;
                    end
                    ST_SN_H: begin
                        r_p  <= horner_coef(r_hk) - r_prod[61:30];
                        r_hk <= r_hk + 2'd1;
                        if (r_hk == 2'd3) begin
                            r_state <= ST_SN_PA;
                        end
                    end
                    ST_SN_PA: begin
                        // negate in the lower half turn
                        r_sin   <= r_turn[31] ? -$signed({1'b0, w_rcap})
                                              : $signed({1'b0, w_rcap});
                        r_state <= r_ret;
                    end
                    ST_SC_RND: begin
                        r_acc   <= 64'(round16({{4{r_acc[63]}}, r_acc}));
                        r_state <= ST_SC_BIAS;
                    end
                    ST_SC_BIAS: begin
                        r_val   <= sat32({{4{r_acc[63]}}, r_acc}
                                         + {{36{r_bias[31]}}, r_bias});
                        r_state <= ST_SC_SCALE;
                    end
                    ST_SC_SCALE: begin
                        r_val   <= sat32(w_rnd);
                        r_axis  <= 1'b0;
                        r_state <= ST_ANG_LO;
                    end
                    ST_ANG_LO: begin
                        r_t32   <= r_prod[63:32];
                        r_state <= ST_ANG_HI;
                    end
                    ST_ANG_HI: begin
                        r_t32   <= r_t32 + r_prod[31:0];
                        r_turn  <= r_t32 + r_prod[31:0] + QUARTER_TURN;
                        r_ret   <= ST_ANG_C;
                        r_state <= ST_SN_A2;
                    end
                    ST_ANG_C: begin
                        if (r_axis) begin
                            r_cz <= r_sin;
                        end else begin
                            r_cy <= r_sin;
                        end
                        r_turn  <= r_t32;
                        r_ret   <= ST_ANG_S;
                        r_state <= ST_SN_A2;
                    end
                    ST_ANG_S: begin
                        if (r_axis) begin
                            r_sz    <= r_sin;
                            r_state <= ST_VX_XY;
                        end else begin
                            r_sy    <= r_sin;
                            r_axis  <= 1'b1;
                            r_state <= ST_ANG_LO;
                        end
                    end
                    ST_VX_XY: begin
                        r_xy    <= w_rnd[33:0];
                        r_state <= ST_VX_X1;
                    end
                    ST_VX_X1: begin
                        r_t1    <= w_rnd[33:0];
                        r_state <= ST_VX_X2;
                    end
                    ST_VX_X2: begin
                        r_x     <= sat32(w_rnd);
                        r_state <= ST_VX_Y1;
                    end
                    ST_VX_Y1: begin
                        r_t1    <= w_rnd[33:0];
                        r_state <= ST_VX_Y2;
                    end
                    ST_VX_Y2: begin
                        r_y     <= sat32(w_rnd);
                        r_state <= ST_VX_Z1;
                    end
                    ST_VX_Z1: begin
                        r_t1    <= -w_rnd[33:0];
                        r_state <= ST_VX_Z2;
                    end
                    ST_VX_Z2: begin
                        // final product stays in r_prod until the output frees
                        r_state <= ST_DONE;
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp <= ONE_Q16)
        else $error("ramp strength above one");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= FRAME_LIMIT)
        else $error("frame position above limit");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished tick did not reach the output register");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HM_C || r_state == ST_HM_S) |-> (6'(r_i) < w_n))
        else $error("harmonic index past term count");

endmodule
